>>> design/tcw_pkg.sv
// Shared types, constants and helpers for the text console writer.
package tcw_pkg;

  // Default screen geometry
  localparam int unsigned DEF_COLUMNS = 80;
  localparam int unsigned DEF_ROWS    = 60;

  // Fixed field widths of the request and result channels
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned POS_W   = 13;
  localparam int unsigned NIB_W   = 4;
  localparam int unsigned DIG_W   = 3;

  localparam logic [CHAR_W-1:0] NL_CODE = 8'd10;

  // Index of the final digit of a hex word (eight digits)
  localparam logic [DIG_W-1:0] LAST_DIGIT = 3'd7;

  // Request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT_CHAR = 2'd0,
    CMD_PUT_HEX  = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_READ     = 2'd3
  } cmd_e;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_in;     // capture the accepted request
    logic do_put;       // put one character at the cursor and emit its result
    logic emit_clear;   // home cursor and emit the clear result
    logic rd_issue;     // start the buffer read for a read request
    logic emit_read;    // emit the read result
    logic sweep_start;  // start a pass over the whole buffer
    logic sweep_copy;   // pass shifts rows up (else zero fill)
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
    logic put_scroll;   // the put of this cycle moves the cursor past the last row
    logic put_more;     // more hex digits follow the put of this cycle
    logic hex_pend;     // hex digits remain after the last put
    logic sweep_busy;   // buffer pass in progress
  } sts_t;

  // Uppercase hex glyphs
  localparam logic [15:0][CHAR_W-1:0] HEX_GLYPHS = {
    8'h46, 8'h45, 8'h44, 8'h43, 8'h42, 8'h41, 8'h39, 8'h38,
    8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
  };

  function automatic logic [CHAR_W-1:0] hex_glyph(input logic [NIB_W-1:0] nib);
    return HEX_GLYPHS[nib];
  endfunction

endpackage

>>> design/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4800,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/tcw_ctrl.sv
// Control state machine of the text console writer.
module tcw_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tcw_pkg::CMD_W-1:0]     command_i,
  input  tcw_pkg::sts_t                 sts_i,
  output tcw_pkg::ctl_t                 ctl_o
);
  import tcw_pkg::*;

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_PUT   = 7'b0000100,
    S_CLR   = 7'b0001000,
    S_RDREQ = 7'b0010000,
    S_RDOUT = 7'b0100000,
    S_SWEEP = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  cmd_e   cmd;

  assign cmd = cmd_e'(command_i);

  // Next state and command decode
  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_INIT: begin
        // clearing pass over the buffer after reset
        ctl_o.sweep_start = 1'b1;
        state_d           = S_SWEEP;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.latch_in = 1'b1;
          unique case (cmd) inside
            CMD_PUT_CHAR, CMD_PUT_HEX: state_d = S_PUT;
            CMD_CLEAR:                 state_d = S_CLR;
            CMD_READ:                  state_d = S_RDREQ;
          endcase
        end
      end
      S_PUT: begin
        if (sts_i.out_free) begin
          ctl_o.do_put = 1'b1;
          if (sts_i.put_scroll) begin
            ctl_o.sweep_start = 1'b1;
            ctl_o.sweep_copy  = 1'b1;
            state_d           = S_SWEEP;
          end else if (!sts_i.put_more) begin
            state_d = S_IDLE;
          end
        end
      end
      S_CLR: begin
        if (sts_i.out_free) begin
          ctl_o.emit_clear  = 1'b1;
          ctl_o.sweep_start = 1'b1;
          state_d           = S_SWEEP;
        end
      end
      S_RDREQ: begin
        ctl_o.rd_issue = 1'b1;
        state_d        = S_RDOUT;
      end
      S_RDOUT: begin
        if (sts_i.out_free) begin
          ctl_o.emit_read = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_SWEEP: begin
        // resume a hex word that scrolled mid-way
        if (!sts_i.sweep_busy) begin
          state_d = sts_i.hex_pend ? S_PUT : S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/tcw_dp.sv
// Datapath: cursor, request capture, buffer sweep, screen RAM and result register.
module tcw_dp #(
  parameter int unsigned COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int unsigned ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcw_pkg::ctl_t                 ctl_i,
  output tcw_pkg::sts_t                 sts_o,
  input  logic [tcw_pkg::CMD_W-1:0]     command_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcw_pkg::WORD_W-1:0]    hex_value_i,
  input  logic [tcw_pkg::POS_W-1:0]     cell_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tcw_pkg::POS_W-1:0]     cursor_pos_o,
  output logic                          redraw_o,
  output logic [tcw_pkg::CHAR_W-1:0]    read_char_o,
  output logic                          last_o
);
  import tcw_pkg::*;

  localparam int unsigned CELLS  = COLUMNS * ROWS;
  localparam int unsigned BOTTOM = CELLS - COLUMNS;
  localparam int unsigned CW     = $clog2(CELLS + 1);
  localparam int unsigned AW     = $clog2(CELLS);
  localparam int unsigned COLW   = $clog2(COLUMNS);
  localparam int unsigned ROWW   = $clog2(ROWS);
  localparam int unsigned PXW    = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned AXW    = (AW > POS_W) ? AW : POS_W;

  // Cursor kept as index plus column and row, so a newline needs no division
  logic [CW-1:0]    cur_q, cur_n;
  logic [COLW-1:0]  col_q, col_n;
  logic [ROWW-1:0]  row_q, row_n;

  // Captured request
  logic              is_hex_q;
  logic [DIG_W-1:0]  dig_q;
  logic [CHAR_W-1:0] char_q;
  logic [WORD_W-1:0] hex_q;
  logic [AW-1:0]     cell_q;
  logic              in_range_q;
  logic [AXW-1:0]    cell_x;

  // Put logic
  logic [CHAR_W-1:0] put_char;
  logic              put_nl;
  logic              row_inc;
  logic              scroll;
  logic              put_last;

  // Sweep unit
  logic              sw_busy_q;
  logic              sw_copy_q;
  logic [CW-1:0]     sw_cnt_q;
  logic              sw_pend_q;
  logic              sw_pend_mem_q;
  logic [AW-1:0]     sw_pend_addr_q;
  logic              sw_issue;
  logic              sw_rd;
  logic [CW-1:0]     sw_src;

  // RAM ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  // Result register
  logic              out_valid_q;
  logic [CW-1:0]     out_cur_q;
  logic              out_redraw_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              out_last_q;
  logic [PXW-1:0]    out_cur_x;
  logic              emit;

  assign cell_x = AXW'(cell_index_i);

  // Character for this put and the cursor move it causes
  always_comb begin
    put_char = is_hex_q ? hex_glyph(hex_q[WORD_W-1 -: NIB_W]) : char_q;
    put_nl   = (put_char == NL_CODE);
    put_last = !is_hex_q || (dig_q == LAST_DIGIT);
    row_inc  = put_nl || (col_q == COLW'(COLUMNS - 1));
    scroll   = row_inc && (row_q == ROWW'(ROWS - 1));
    if (put_nl) begin
      cur_n = cur_q + CW'(COLUMNS) - CW'(col_q);
    end else begin
      cur_n = cur_q + CW'(1);
    end
    col_n = row_inc ? '0 : col_q + COLW'(1);
    row_n = row_inc ? row_q + ROWW'(1) : row_q;
    if (scroll) begin
      cur_n = CW'(BOTTOM);
      col_n = '0;
      row_n = ROWW'(ROWS - 1);
    end
  end

  // Cursor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      col_q <= '0;
      row_q <= '0;
    end else if (ctl_i.emit_clear) begin
      cur_q <= '0;
      col_q <= '0;
      row_q <= '0;
    end else if (ctl_i.do_put) begin
      cur_q <= cur_n;
      col_q <= col_n;
      row_q <= row_n;
    end
  end

  // Request control state: hex mode and digit count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_hex_q <= 1'b0;
      dig_q    <= '0;
    end else if (ctl_i.latch_in) begin
      is_hex_q <= (cmd_e'(command_i) == CMD_PUT_HEX);
      dig_q    <= '0;
    end else if (ctl_i.do_put) begin
      dig_q <= dig_q + DIG_W'(1);
    end
  end

  // Request payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch_in) begin
      char_q     <= char_code_i;
      hex_q      <= hex_value_i;
      cell_q     <= cell_x[AW-1:0];
      in_range_q <= (32'(cell_index_i) < 32'(CELLS));
    end else if (ctl_i.do_put) begin
      hex_q <= hex_q << NIB_W;
    end
  end

  // Sweep: read cell i+COLUMNS, write it to cell i in the next cycle;
  // zero mode or the bottom row writes zero
  assign sw_issue = sw_busy_q && (sw_cnt_q < CW'(CELLS));
  assign sw_rd    = sw_issue && sw_copy_q && (sw_cnt_q < CW'(BOTTOM));
  assign sw_src   = sw_cnt_q + CW'(COLUMNS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_busy_q <= 1'b0;
      sw_copy_q <= 1'b0;
      sw_cnt_q  <= '0;
      sw_pend_q <= 1'b0;
    end else if (ctl_i.sweep_start) begin
      sw_busy_q <= 1'b1;
      sw_copy_q <= ctl_i.sweep_copy;
      sw_cnt_q  <= '0;
      sw_pend_q <= 1'b0;
    end else if (sw_busy_q) begin
      sw_pend_q <= sw_issue;
      if (sw_issue) begin
        sw_cnt_q <= sw_cnt_q + CW'(1);
      end else begin
        sw_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sw_issue) begin
      sw_pend_addr_q <= sw_cnt_q[AW-1:0];
      sw_pend_mem_q  <= sw_rd;
    end
  end

  // RAM port selection
  always_comb begin
    if (sw_pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = sw_pend_addr_q;
      ram_wdata = sw_pend_mem_q ? ram_rdata : '0;
    end else begin
      ram_we    = ctl_i.do_put && !put_nl;
      ram_waddr = cur_q[AW-1:0];
      ram_wdata = put_char;
    end
    ram_re    = sw_rd || ctl_i.rd_issue;
    ram_raddr = sw_rd ? sw_src[AW-1:0] : cell_q;
  end

  tcw_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result register
  assign emit = ctl_i.do_put || ctl_i.emit_clear || ctl_i.emit_read;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.do_put) begin
      out_cur_q    <= cur_n;
      out_redraw_q <= put_nl;
      out_char_q   <= '0;
      out_last_q   <= put_last;
    end else if (ctl_i.emit_clear) begin
      out_cur_q    <= '0;
      out_redraw_q <= 1'b1;
      out_char_q   <= '0;
      out_last_q   <= 1'b1;
    end else if (ctl_i.emit_read) begin
      out_cur_q    <= cur_q;
      out_redraw_q <= 1'b0;
      out_char_q   <= in_range_q ? ram_rdata : '0;
      out_last_q   <= 1'b1;
    end
  end

  assign out_cur_x    = PXW'(out_cur_q);
  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = out_cur_x[POS_W-1:0];
  assign redraw_o     = out_redraw_q;
  assign read_char_o  = out_char_q;
  assign last_o       = out_last_q;

  // Status to the controller
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.put_scroll = scroll;
  assign sts_o.put_more   = !put_last;
  assign sts_o.hex_pend   = is_hex_q && (dig_q != '0);
  assign sts_o.sweep_busy = sw_busy_q;

endmodule

>>> design/text_console_writer_top.sv
// Text console writer: top level joining the controller and the datapath.
//
// A COLUMNS x ROWS character screen held in one RAM, with a cursor. Requests
// come in on a valid/ready channel; results leave through an output register
// on a second valid/ready channel, so a finished result may wait while the next
// request is taken. A hex word gives one result per digit. Every buffer pass
// (clear, and scrolling when the cursor runs past the last row) walks the RAM
// one cell per cycle through its single write port, and no request is accepted
// while it runs. After reset a clearing pass runs before the first request is
// taken.
module text_console_writer_top #(
  parameter int unsigned COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int unsigned ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tcw_pkg::CMD_W-1:0]     command_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcw_pkg::WORD_W-1:0]    hex_value_i,
  input  logic [tcw_pkg::POS_W-1:0]     cell_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tcw_pkg::POS_W-1:0]     cursor_pos_o,
  output logic                          redraw_o,
  output logic [tcw_pkg::CHAR_W-1:0]    read_char_o,
  output logic                          last_o
);
  import tcw_pkg::*;

  ctl_t ctl;
  sts_t sts;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .command_i    (command_i),
    .char_code_i  (char_code_i),
    .hex_value_i  (hex_value_i),
    .cell_index_i (cell_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cursor_pos_o (cursor_pos_o),
    .redraw_o     (redraw_o),
    .read_char_o  (read_char_o),
    .last_o       (last_o)
  );

endmodule
